// ===== src/rsst_pkg.sv =====
// ----------------------------------------------------------------------------
// rsst_pkg: shared types and constants for the ring slot scan range tracker
// slot, time and segment widths plus the segment table entry layout
// ----------------------------------------------------------------------------
package rsst_pkg;

   localparam int unsigned SLOT_W       = 21;  // pool size, scan extent, end slot
   localparam int unsigned CURSOR_W     = 20;  // ring cursor
   localparam int unsigned COUNT_IN_W   = 24;  // requested slot count
   localparam int unsigned LIFE_W       = 32;  // segment lifetime
   localparam int unsigned STEP_W       = 24;  // tick time step
   localparam int unsigned TIME_W       = 48;  // elapsed time and deadlines
   localparam int unsigned LIVE_W       = 6;   // live segment count on the result
   localparam int unsigned BIT_W        = $clog2(SLOT_W);

   localparam int unsigned MAX_POOL_SLOTS    = 1048576;
   localparam int unsigned SEGMENT_DEPTH_DEF = 32;
   localparam logic [SLOT_W-1:0] POOL_MAX   = SLOT_W'(MAX_POOL_SLOTS);
   localparam logic [SLOT_W-1:0] POOL_RESET = SLOT_W'(65536);

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef struct packed {
      logic [SLOT_W-1:0] end_slot;
      logic [TIME_W-1:0] deadline;
   } seg_entry_type;

endpackage

// ===== src/ring_slot_scan_range_tracker.sv =====
// ----------------------------------------------------------------------------
// ring_slot_scan_range_tracker: ring allocator scan range tracker
// steps: allocate clamps, adds, checks wrap, runs a bit-serial cursor modulo, sets
//   deadline, stores or merges, raises extent; a zero allocate is ignored; a tick
//   advances time, then walks the stored segments; one item at a time; ready returns
//   with the registered result, held off while a prior result waits on rsp_ready
// reset: synchronous active high; cursor, extent, flags, time and count clear,
//   pool size returns to 65536; segment table is not cleared
// ----------------------------------------------------------------------------
module ring_slot_scan_range_tracker #(
   parameter int unsigned SEGMENT_DEPTH = rsst_pkg::SEGMENT_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [rsst_pkg::SLOT_W-1:0]       csr_wr_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [rsst_pkg::COUNT_IN_W-1:0]   req_slot_count,
   input  logic [rsst_pkg::LIFE_W-1:0]       req_lifetime,
   input  logic [rsst_pkg::STEP_W-1:0]       req_time_step,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rsst_pkg::SLOT_W-1:0]       rsp_scan_extent,
   output logic [rsst_pkg::CURSOR_W-1:0]     rsp_ring_position,
   output logic                              rsp_has_wrapped,
   output logic                              rsp_rewind_issued,
   output logic                              rsp_segment_merged,
   output logic [rsst_pkg::LIVE_W-1:0]       rsp_live_segments
);

   localparam int unsigned IDX_W = $clog2(SEGMENT_DEPTH);
   localparam int unsigned CNT_W = $clog2(SEGMENT_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEGMENT_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SEGMENT_DEPTH);

   localparam int unsigned SW = rsst_pkg::SLOT_W;
   localparam int unsigned TW = rsst_pkg::TIME_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_A_CLAMP = 4'd1;   // clamp request to pool
   localparam logic [3:0] ST_A_END   = 4'd2;   // cursor + n
   localparam logic [3:0] ST_A_WRAP  = 4'd3;   // end >= pool sets wrapped
   localparam logic [3:0] ST_A_MOD   = 4'd4;   // bit-serial end mod pool
   localparam logic [3:0] ST_A_DLINE = 4'd5;   // deadline, end slot
   localparam logic [3:0] ST_A_STORE = 4'd6;   // append or go merge
   localparam logic [3:0] ST_A_M_END = 4'd7;   // merge: max end slot
   localparam logic [3:0] ST_A_M_DL  = 4'd8;   // merge: later deadline, write
   localparam logic [3:0] ST_A_SCAN  = 4'd9;   // raise high-water extent
   localparam logic [3:0] ST_T_TIME  = 4'd10;  // advance elapsed time
   localparam logic [3:0] ST_T_DL    = 4'd11;  // entry expired?
   localparam logic [3:0] ST_T_END   = 4'd12;  // keep entry, track max end
   localparam logic [3:0] ST_T_FIN   = 4'd13;  // rewind or shrink extent
   localparam logic [3:0] ST_RESP    = 4'd14;  // hand result to output register

   logic [3:0]            state_ff, state_in;

   // configuration, stored already clamped to the legal pool range
   logic [SW-1:0]         pool_ff, pool_in;

   // architectural state
   logic [rsst_pkg::CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [SW-1:0]         scan_ff, scan_in;
   logic                  wrapped_ff, wrapped_in;
   logic [TW-1:0]         elapsed_ff, elapsed_in;
   logic                  pending_ff, pending_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   // per-item working registers
   logic [rsst_pkg::COUNT_IN_W-1:0] n_ff, n_in;
   logic [rsst_pkg::LIFE_W-1:0]     life_ff, life_in;
   logic [rsst_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [SW-1:0]         end_ff, end_in;
   logic [SW-1:0]         rem_ff, rem_in;
   logic [rsst_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic [SW-1:0]         end_slot_ff, end_slot_in;
   logic [SW-1:0]         mrg_end_ff, mrg_end_in;
   logic [TW-1:0]         dline_ff, dline_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [SW-1:0]         max_end_ff, max_end_in;
   logic                  merged_ff, merged_in;
   logic                  rewound_ff, rewound_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]         o_scan_ff, o_scan_in;
   logic [rsst_pkg::CURSOR_W-1:0] o_pos_ff, o_pos_in;
   logic                  o_wrap_ff, o_wrap_in;
   logic                  o_rew_ff, o_rew_in;
   logic                  o_mrg_ff, o_mrg_in;
   logic [rsst_pkg::LIVE_W-1:0]   o_live_ff, o_live_in;

   // shared adder
   logic                  alu_sub;
   logic [TW-1:0]         alu_a, alu_b;
   logic [TW:0]           alu_res;
   logic                  alu_co;
   logic [TW-1:0]         alu_sat;

   // segment table
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa, mem_ra;
   rsst_pkg::seg_entry_type mem_wd, mem_rd;

   logic                  req_xfer;
   logic [SW-1:0]         rem_sh;
   logic                  tick_phase;

   rsst_alu u_alu (
      .op_sub (alu_sub),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_res)
   );

   rsst_seg_mem #(
      .DEPTH (SEGMENT_DEPTH)
   ) u_seg_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign alu_co  = alu_res[TW];
   // saturating sum for time adds: overflow past 48 bits pins to all ones
   assign alu_sat = alu_co ? {TW{1'b1}} : alu_res[TW-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // next partial remainder of the cursor modulo, one dividend bit per cycle
   assign rem_sh = {rem_ff[SW-2:0], end_ff[bit_ff]};

   // during a tick the read port runs one step ahead on the scan index;
   // otherwise it sits on the last entry for a possible merge
   assign tick_phase = (state_ff == ST_T_TIME) || (state_ff == ST_T_DL) ||
                       (state_ff == ST_T_END);
   assign mem_ra = tick_phase ? rd_idx_in[IDX_W-1:0] : LAST_IDX;

   // configuration write with pool clamp: zero acts as one, cap at max
   always_comb begin
      pool_in = pool_ff;
      if (csr_wr_en) begin
         priority if (csr_wr_data == '0) begin
            pool_in = SW'(1);
         end else if (csr_wr_data > rsst_pkg::POOL_MAX) begin
            pool_in = rsst_pkg::POOL_MAX;
         end else begin
            pool_in = csr_wr_data;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      scan_in     = scan_ff;
      wrapped_in  = wrapped_ff;
      elapsed_in  = elapsed_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      life_in     = life_ff;
      step_in     = step_ff;
      end_in      = end_ff;
      rem_in      = rem_ff;
      bit_in      = bit_ff;
      end_slot_in = end_slot_ff;
      mrg_end_in  = mrg_end_ff;
      dline_in    = dline_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      max_end_in  = max_end_ff;
      merged_in   = merged_ff;
      rewound_in  = rewound_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_scan_in    = o_scan_ff;
      o_pos_in     = o_pos_ff;
      o_wrap_in    = o_wrap_ff;
      o_rew_in     = o_rew_ff;
      o_mrg_in     = o_mrg_ff;
      o_live_in    = o_live_ff;

      alu_sub = 1'b1;
      alu_a   = '0;
      alu_b   = '0;

      mem_we = 1'b0;
      mem_wa = count_ff[IDX_W-1:0];
      mem_wd = '{end_slot: end_slot_ff, deadline: dline_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               n_in       = req_slot_count;
               life_in    = req_lifetime;
               step_in    = req_time_step;
               merged_in  = 1'b0;
               rewound_in = 1'b0;
               rd_idx_in  = '0;
               wr_idx_in  = '0;
               max_end_in = '0;
               priority if (req_type == rsst_pkg::REQ_TICK) begin
                  state_in = ST_T_TIME;
               end else if (req_slot_count == '0) begin
                  // zero request leaves all state alone
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_A_CLAMP;
               end
            end
         end

         ST_A_CLAMP: begin
            // pool - n; a borrow means the request is larger than the pool
            alu_a = TW'(pool_ff);
            alu_b = TW'(n_ff);
            if (!alu_co) begin
               n_in = rsst_pkg::COUNT_IN_W'(pool_ff);
            end
            state_in = ST_A_END;
         end

         ST_A_END: begin
            alu_sub  = 1'b0;
            alu_a    = TW'(cursor_ff);
            alu_b    = TW'(n_ff);
            end_in   = alu_res[SW-1:0];
            state_in = ST_A_WRAP;
         end

         ST_A_WRAP: begin
            alu_a = TW'(end_ff);
            alu_b = TW'(pool_ff);
            if (alu_co) begin
               wrapped_in = 1'b1;
            end
            rem_in   = '0;
            bit_in   = rsst_pkg::BIT_W'(SW - 1);
            state_in = ST_A_MOD;
         end

         ST_A_MOD: begin
            // restoring remainder step: shift in a bit, subtract pool if it fits
            alu_a  = TW'(rem_sh);
            alu_b  = TW'(pool_ff);
            rem_in = alu_co ? alu_res[SW-1:0] : rem_sh;
            if (bit_ff == '0) begin
               cursor_in = rem_in[rsst_pkg::CURSOR_W-1:0];
               state_in  = ST_A_DLINE;
            end else begin
               bit_in = bit_ff - rsst_pkg::BIT_W'(1);
            end
         end

         ST_A_DLINE: begin
            alu_sub     = 1'b0;
            alu_a       = elapsed_ff;
            alu_b       = TW'(life_ff);
            dline_in    = alu_sat;
            end_slot_in = wrapped_ff ? pool_ff : end_ff;
            state_in    = ST_A_STORE;
         end

         ST_A_STORE: begin
            if (count_ff == FULL_CNT) begin
               state_in = ST_A_M_END;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = count_ff[IDX_W-1:0];
               count_in = count_ff + CNT_W'(1);
               state_in = ST_A_SCAN;
            end
         end

         ST_A_M_END: begin
            alu_a      = TW'(end_slot_ff);
            alu_b      = TW'(mem_rd.end_slot);
            mrg_end_in = alu_co ? end_slot_ff : mem_rd.end_slot;
            state_in   = ST_A_M_DL;
         end

         ST_A_M_DL: begin
            alu_a     = dline_ff;
            alu_b     = mem_rd.deadline;
            mem_we    = 1'b1;
            mem_wa    = LAST_IDX;
            mem_wd    = '{end_slot: mrg_end_ff,
                          deadline: alu_co ? dline_ff : mem_rd.deadline};
            merged_in = 1'b1;
            state_in  = ST_A_SCAN;
         end

         ST_A_SCAN: begin
            alu_a = TW'(end_slot_ff);
            alu_b = TW'(scan_ff);
            if (alu_co) begin
               scan_in = end_slot_ff;
            end
            pending_in = 1'b1;
            state_in   = ST_RESP;
         end

         ST_T_TIME: begin
            alu_sub    = 1'b0;
            alu_a      = elapsed_ff;
            alu_b      = TW'(step_ff);
            elapsed_in = alu_sat;
            state_in   = ST_T_DL;
         end

         ST_T_DL: begin
            // elapsed - deadline; no borrow means the entry has expired
            alu_a = elapsed_ff;
            alu_b = mem_rd.deadline;
            priority if (rd_idx_ff == count_ff) begin
               state_in = ST_T_FIN;
            end else if (alu_co) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_T_END;
            end
         end

         ST_T_END: begin
            // live entry: compact it down and track the largest end slot
            alu_a = TW'(mem_rd.end_slot);
            alu_b = TW'(max_end_ff);
            if (alu_co) begin
               max_end_in = mem_rd.end_slot;
            end
            mem_we    = 1'b1;
            mem_wa    = wr_idx_ff[IDX_W-1:0];
            mem_wd    = mem_rd;
            wr_idx_in = wr_idx_ff + CNT_W'(1);
            rd_idx_in = rd_idx_ff + CNT_W'(1);
            state_in  = ST_T_DL;
         end

         ST_T_FIN: begin
            count_in = wr_idx_ff;
            priority if ((wr_idx_ff == '0) && !pending_ff) begin
               // nothing live and no fresh allocation: rewind the ring
               if (scan_ff != '0) begin
                  cursor_in  = '0;
                  wrapped_in = 1'b0;
                  rewound_in = 1'b1;
               end
               scan_in = '0;
            end else if (!wrapped_ff) begin
               scan_in = max_end_ff;
            end else begin
               scan_in = scan_ff;
            end
            pending_in = 1'b0;
            state_in   = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_scan_in    = scan_ff;
               o_pos_in     = cursor_ff;
               o_wrap_in    = wrapped_ff;
               o_rew_in     = rewound_ff;
               o_mrg_in     = merged_ff;
               o_live_in    = rsst_pkg::LIVE_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pool_ff      <= rsst_pkg::POOL_RESET;
         cursor_ff    <= '0;
         scan_ff      <= '0;
         wrapped_ff   <= 1'b0;
         elapsed_ff   <= '0;
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         cursor_ff    <= cursor_in;
         scan_ff      <= scan_in;
         wrapped_ff   <= wrapped_in;
         elapsed_ff   <= elapsed_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      life_ff     <= life_in;
      step_ff     <= step_in;
      end_ff      <= end_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      end_slot_ff <= end_slot_in;
      mrg_end_ff  <= mrg_end_in;
      dline_ff    <= dline_in;
      rd_idx_ff   <= rd_idx_in;
      wr_idx_ff   <= wr_idx_in;
      max_end_ff  <= max_end_in;
      merged_ff   <= merged_in;
      rewound_ff  <= rewound_in;
      o_scan_ff   <= o_scan_in;
      o_pos_ff    <= o_pos_in;
      o_wrap_ff   <= o_wrap_in;
      o_rew_ff    <= o_rew_in;
      o_mrg_ff    <= o_mrg_in;
      o_live_ff   <= o_live_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_scan_extent    = o_scan_ff;
   assign rsp_ring_position  = o_pos_ff;
   assign rsp_has_wrapped    = o_wrap_ff;
   assign rsp_rewind_issued  = o_rew_ff;
   assign rsp_segment_merged = o_mrg_ff;
   assign rsp_live_segments  = o_live_ff;

endmodule

// ===== src/rsst_alu.sv =====
// ----------------------------------------------------------------------------
// rsst_alu: shared add / subtract unit
// one 48-bit adder; carry out is overflow on add and a >= b on subtract
// ----------------------------------------------------------------------------
module rsst_alu (
   input  logic                          op_sub,
   input  logic [rsst_pkg::TIME_W-1:0]   op_a,
   input  logic [rsst_pkg::TIME_W-1:0]   op_b,
   output logic [rsst_pkg::TIME_W:0]     result
);

   logic [rsst_pkg::TIME_W:0] b_ext;

   assign b_ext  = {1'b0, op_b ^ {rsst_pkg::TIME_W{op_sub}}};
   assign result = {1'b0, op_a} + b_ext + (rsst_pkg::TIME_W + 1)'(op_sub);

endmodule

// ===== src/rsst_seg_mem.sv =====
// ----------------------------------------------------------------------------
// rsst_seg_mem: segment table storage
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rsst_seg_mem #(
   parameter int unsigned DEPTH = rsst_pkg::SEGMENT_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  rsst_pkg::seg_entry_type       wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output rsst_pkg::seg_entry_type       rd_data
);

   rsst_pkg::seg_entry_type mem [DEPTH];
   rsst_pkg::seg_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for ring_slot_scan_range_tracker
// sends allocate and tick transfers with random idling on both channels, keeps
// a behavioral copy of the tracker state to predict every response and checks
// each response field by field, in order of arrival
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned SLOT_W         = rsst_pkg::SLOT_W;
   localparam int unsigned CURSOR_W       = rsst_pkg::CURSOR_W;
   localparam int unsigned COUNT_IN_W     = rsst_pkg::COUNT_IN_W;
   localparam int unsigned LIFE_W         = rsst_pkg::LIFE_W;
   localparam int unsigned STEP_W         = rsst_pkg::STEP_W;
   localparam int unsigned TIME_W         = rsst_pkg::TIME_W;
   localparam int unsigned LIVE_W         = rsst_pkg::LIVE_W;
   localparam int unsigned MAX_POOL_SLOTS = rsst_pkg::MAX_POOL_SLOTS;
   localparam logic [SLOT_W-1:0] POOL_MAX   = rsst_pkg::POOL_MAX;
   localparam logic [SLOT_W-1:0] POOL_RESET = rsst_pkg::POOL_RESET;

   localparam int unsigned DEPTH       = rsst_pkg::SEGMENT_DEPTH_DEF;
   localparam int unsigned LIFE_UNIT   = 65536;   // 1.0 in 16.16 fixed point
   localparam int unsigned RANDOM_STOP = 1230;    // request count that ends random traffic
   localparam logic        REQ_ALLOC   = rsst_pkg::REQ_ALLOC;
   localparam logic        REQ_TICK    = rsst_pkg::REQ_TICK;
   localparam logic [TIME_W-1:0] TIME_SAT = '1;

   // pool sizes walked by the random traffic, extremes and out-of-range values included
   localparam logic [SLOT_W-1:0] POOL_PLAN [12] = '{
      21'd1, 21'd2, 21'd3, 21'd16, 21'd100, 21'd1000, 21'd4096, 21'd65535,
      21'd1048575, POOL_MAX, 21'h1F_FFFF, 21'd0
   };

   typedef struct packed {
      logic                  kind;
      logic [COUNT_IN_W-1:0] slots;
      logic [LIFE_W-1:0]     life;
      logic [STEP_W-1:0]     step;
   } tracker_op_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   extent;
      logic [CURSOR_W-1:0] cursor;
      logic                wrapped;
      logic                rewound;
      logic                merged;
      logic [LIVE_W-1:0]   live;
   } tracker_status_type;

   // dut ports, inputs all driven to known values from time zero
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_wr_en      = 1'b0;
   logic [SLOT_W-1:0]     csr_wr_data    = '0;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic                  req_type       = REQ_ALLOC;
   logic [COUNT_IN_W-1:0] req_slot_count = '0;
   logic [LIFE_W-1:0]     req_lifetime   = '0;
   logic [STEP_W-1:0]     req_time_step  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [SLOT_W-1:0]     rsp_scan_extent;
   logic [CURSOR_W-1:0]   rsp_ring_position;
   logic                  rsp_has_wrapped;
   logic                  rsp_rewind_issued;
   logic                  rsp_segment_merged;
   logic [LIVE_W-1:0]     rsp_live_segments;

   // predicted tracker state, mirrors the block after every accepted request
   logic [SLOT_W-1:0]   pool_setting     = POOL_RESET;
   logic [CURSOR_W-1:0] ring_cursor      = '0;
   logic [SLOT_W-1:0]   scan_mark        = '0;
   logic                wrap_seen        = 1'b0;
   logic [TIME_W-1:0]   elapsed          = '0;
   logic                alloc_since_tick = 1'b0;
   logic [SLOT_W-1:0]   seg_end      [DEPTH];
   logic [TIME_W-1:0]   seg_deadline [DEPTH];
   int unsigned         seg_live         = 0;

   tracker_status_type expected_status_q [$];

   int unsigned items_sent = 0;
   int unsigned rsp_seen   = 0;
   int unsigned failures   = 0;
   int unsigned stall_left = 0;
   bit          calm       = 1'b0;   // no idling on either channel while set

   ring_slot_scan_range_tracker dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_slot_count     (req_slot_count),
      .req_lifetime       (req_lifetime),
      .req_time_step      (req_time_step),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scan_extent    (rsp_scan_extent),
      .rsp_ring_position  (rsp_ring_position),
      .rsp_has_wrapped    (rsp_has_wrapped),
      .rsp_rewind_issued  (rsp_rewind_issued),
      .rsp_segment_merged (rsp_segment_merged),
      .rsp_live_segments  (rsp_live_segments)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   function automatic logic [TIME_W-1:0] add_time_sat(logic [TIME_W-1:0] base,
                                                      logic [TIME_W-1:0] delta);
      logic [TIME_W:0] sum;
      sum = {1'b0, base} + {1'b0, delta};
      return sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
   endfunction

   // applies one request to the predicted state and returns the status it reports
   function automatic tracker_status_type advance_tracker(tracker_op_type op);
      tracker_status_type    res;
      logic [SLOT_W-1:0]     pool;
      logic [SLOT_W-1:0]     end_slot;
      logic [SLOT_W-1:0]     widest;
      logic [SLOT_W:0]       run_end;
      logic [COUNT_IN_W-1:0] n;
      logic [TIME_W-1:0]     deadline;
      int unsigned           kept;
      int unsigned           i;
      res = '0;
      if (op.kind == REQ_ALLOC) begin
         // a zero request leaves everything alone
         if (op.slots != '0) begin
            // zero pool acts as one slot, oversized pool is capped
            pool = (pool_setting == '0) ? SLOT_W'(1) :
                   (pool_setting > POOL_MAX) ? POOL_MAX : pool_setting;
            n = (op.slots > COUNT_IN_W'(pool)) ? COUNT_IN_W'(pool) : op.slots;
            alloc_since_tick = 1'b1;
            // a cursor left above a shrunk pool is reduced here
            run_end = (SLOT_W+1)'(ring_cursor) + (SLOT_W+1)'(n);
            if (run_end >= (SLOT_W+1)'(pool)) wrap_seen = 1'b1;
            ring_cursor = CURSOR_W'(run_end % (SLOT_W+1)'(pool));
            end_slot = wrap_seen ? pool : SLOT_W'(run_end);
            deadline = add_time_sat(elapsed, TIME_W'(op.life));
            if (seg_live >= DEPTH) begin
               // table full: fold into the last entry
               if (end_slot > seg_end[DEPTH-1]) seg_end[DEPTH-1] = end_slot;
               if (deadline > seg_deadline[DEPTH-1]) seg_deadline[DEPTH-1] = deadline;
               res.merged = 1'b1;
            end else begin
               seg_end[seg_live] = end_slot;
               seg_deadline[seg_live] = deadline;
               seg_live++;
            end
            if (end_slot > scan_mark) scan_mark = end_slot;
         end
      end else begin
         elapsed = add_time_sat(elapsed, TIME_W'(op.step));
         widest = '0;
         kept = 0;
         // compact the table, keeping only segments still alive
         for (i = 0; i < seg_live; i++) begin
            if (seg_deadline[i] > elapsed) begin
               if (seg_end[i] > widest) widest = seg_end[i];
               seg_end[kept] = seg_end[i];
               seg_deadline[kept] = seg_deadline[i];
               kept++;
            end
         end
         seg_live = kept;
         if (seg_live == 0 && !alloc_since_tick) begin
            if (scan_mark != '0) begin
               ring_cursor = '0;
               wrap_seen = 1'b0;
               res.rewound = 1'b1;
            end
            scan_mark = '0;
         end else if (!wrap_seen) begin
            scan_mark = widest;
         end
         alloc_since_tick = 1'b0;
      end
      res.extent = scan_mark;
      res.cursor = ring_cursor;
      res.wrapped = wrap_seen;
      res.live = LIVE_W'(seg_live);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // random value pickers
   // ------------------------------------------------------------------

   // idle length: mostly none or short, a few long
   function automatic int unsigned pick_idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // slot counts scaled to the pool so wraps come now and then, plus oversized ones
   function automatic logic [COUNT_IN_W-1:0] pick_slots();
      int unsigned lim;
      int unsigned roll;
      lim = int'(pool_setting);
      if (lim == 0) lim = 1;
      if (lim > MAX_POOL_SLOTS) lim = MAX_POOL_SLOTS;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 70) return COUNT_IN_W'($urandom_range(1, (lim + 7) / 8));
      if (roll < 90) return COUNT_IN_W'($urandom_range(1, lim));
      return COUNT_IN_W'($urandom);
   endfunction

   // lifetimes kept short enough that segments expire within a few ticks
   function automatic logic [LIFE_W-1:0] pick_life();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return LIFE_W'($urandom_range(0, 255));
      if (roll < 75) return LIFE_W'($urandom_range(0, 4 * LIFE_UNIT));
      if (roll < 95) return LIFE_W'($urandom_range(0, 32 * LIFE_UNIT));
      return LIFE_W'($urandom_range(0, 24'hFF_FFFF));
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return '0;
      if (roll < 70) return STEP_W'($urandom_range(0, LIFE_UNIT));
      if (roll < 95) return STEP_W'($urandom_range(0, 4 * LIFE_UNIT));
      return STEP_W'($urandom);
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // entered and left at a falling edge; valid stays high after the transfer
   // so that a back-to-back request keeps it up without a glitch
   task automatic send_item(tracker_op_type op);
      int unsigned gap;
      gap = calm ? 0 : pick_idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op.kind;
      req_slot_count <= op.slots;
      req_lifetime   <= op.life;
      req_time_step  <= op.step;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      // predict after the transfer, well before its response can arrive
      expected_status_q.insert(expected_status_q.size(), advance_tracker(op));
      items_sent++;
   endtask

   // fields that an item does not use carry random values
   task automatic alloc_run(logic [COUNT_IN_W-1:0] count, logic [LIFE_W-1:0] life_v);
      tracker_op_type op;
      op.kind  = REQ_ALLOC;
      op.slots = count;
      op.life  = life_v;
      op.step  = STEP_W'($urandom);
      send_item(op);
   endtask

   task automatic tick_time(logic [STEP_W-1:0] step_v);
      tracker_op_type op;
      op.kind  = REQ_TICK;
      op.slots = COUNT_IN_W'($urandom);
      op.life  = LIFE_W'($urandom);
      op.step  = step_v;
      send_item(op);
   endtask

   // drop valid and wait until every response is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_status_q.size() != 0);
   endtask

   task automatic write_pool(logic [SLOT_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pool_setting = value;
   endtask

   // tick until no segment is live, then once more so the cursor can rewind
   task automatic drain_segments();
      while (seg_live != 0) tick_time(STEP_W'($urandom_range(LIFE_UNIT, 16 * LIFE_UNIT)));
      tick_time(pick_step());
   endtask

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_idle_len();
         rsp_ready <= (stall_left == 0);
      end
   end

   function automatic void note_failure(string what);
      failures++;
      if (failures <= 10) $display("%0t: response %0d: %s", $time, rsp_seen, what);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
         note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
   endfunction

   always @(posedge clock) begin : check_status
      tracker_status_type want;
      tracker_status_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status_q.size() == 0) begin
            note_failure("response transfer with no request outstanding");
         end else begin
            want = expected_status_q.pop_front();
            got = {rsp_scan_extent, rsp_ring_position, rsp_has_wrapped,
                   rsp_rewind_issued, rsp_segment_merged, rsp_live_segments};
            check_field("scan_extent", 32'(want.extent), 32'(got.extent));
            check_field("ring_position", 32'(want.cursor), 32'(got.cursor));
            check_field("has_wrapped", 32'(want.wrapped), 32'(got.wrapped));
            check_field("rewind_issued", 32'(want.rewound), 32'(got.rewound));
            check_field("segment_merged", 32'(want.merged), 32'(got.merged));
            check_field("live_segments", 32'(want.live), 32'(got.live));
         end
         rsp_seen++;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset pool size: empty tick, zero request, clamp, instant expiry, rewind
   task automatic test_basic_flow();
      tick_time('0);                         // nothing to rewind yet
      alloc_run('0, LIFE_W'($urandom));      // zero request is dropped
      alloc_run(24'd1, LIFE_W'(LIFE_UNIT));
      alloc_run(24'hFF_FFFF, '0);            // clamps to the pool and wraps
      tick_time('0);                         // zero-life segment dies at once
      tick_time(STEP_W'(LIFE_UNIT));         // last segment dies, cursor rewinds
      tick_time(24'd3);                      // idle tick, no second rewind
   endtask

   task automatic test_pool_extremes();
      write_pool(21'd1);
      alloc_run(24'd3, 32'd16);
      tick_time(24'd256);                    // expires but an allocate is pending
      tick_time('0);
      write_pool(21'd0);                     // behaves as a one-slot pool
      alloc_run(24'd2, '0);
      tick_time('0);
      tick_time('0);
      write_pool(21'h1F_FFFF);               // above the maximum, capped
      alloc_run(24'hFF_FFFF, 32'd1);         // full pool: widest scan extent
      tick_time(24'd1);
      tick_time('0);
      write_pool(POOL_MAX);
      alloc_run(24'h0F_FFFF, 32'd2);         // cursor at its top value
      alloc_run(24'd1, 32'd2);               // lands exactly on the pool end
      tick_time(24'd2);
   endtask

   // cursor stays above a shrunk pool until the next allocate reduces it
   task automatic test_pool_shrink();
      write_pool(21'd1000);
      alloc_run(24'd900, LIFE_W'(LIFE_UNIT));
      write_pool(21'd100);
      tick_time('0);
      alloc_run(24'd5, '0);
      tick_time(STEP_W'(2 * LIFE_UNIT));
      tick_time('0);
   endtask

   // overflow the segment table so new runs fold into the last entry
   task automatic test_table_full();
      write_pool(21'd4096);
      repeat ($urandom_range(36, 44)) begin
         alloc_run(COUNT_IN_W'($urandom_range(1, 300)),
                   LIFE_W'($urandom_range(4 * LIFE_UNIT, 8 * LIFE_UNIT)));
         if ($urandom_range(0, 9) < 2) tick_time(STEP_W'($urandom_range(0, LIFE_UNIT / 4)));
      end
      drain_segments();
   endtask

   // bursts of allocations followed by draining, mixed with unordered noise,
   // over the pool plan and then random pool sizes
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned phase_end;
      int unsigned burst;
      phase = 0;
      while (items_sent < RANDOM_STOP) begin
         if (phase < 12) write_pool(POOL_PLAN[phase]);
         else if ($urandom_range(0, 1) != 0) write_pool(SLOT_W'($urandom_range(1, 5000)));
         else write_pool(SLOT_W'($urandom));
         phase++;
         phase_end = items_sent + 90;
         while (items_sent < phase_end) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
               burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                   : $urandom_range(1, 10);
               repeat (burst) begin
                  alloc_run(pick_slots(), pick_life());
                  if ($urandom_range(0, 9) < 3) tick_time(pick_step());
               end
               drain_segments();
            end else begin
               repeat ($urandom_range(8, 20)) begin
                  if ($urandom_range(0, 1) != 0) alloc_run(pick_slots(), pick_life());
                  else tick_time(pick_step());
               end
            end
         end
      end
   endtask

   // longest lifetime, outlived only by a long run of largest time steps
   task automatic test_long_lifetime();
      calm = 1'b0;
      write_pool(21'd64);
      alloc_run(COUNT_IN_W'($urandom_range(1, 64)), '1);
      while (seg_live != 0) begin
         tick_time('1);
         if ($urandom_range(0, 3) == 0) alloc_run(pick_slots(), pick_life());
      end
      tick_time(pick_step());
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_flow();
      test_pool_extremes();
      test_pool_shrink();
      test_table_full();
      test_random_traffic();
      test_long_lifetime();
      wait_idle();
      // longest tick walks the whole table, so allow a little more than that
      repeat (80) @(negedge clock);
      if (expected_status_q.size() != 0) note_failure("responses missing at end of run");
      if (failures == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
